// ===== hdl/yuv420_to_rgb555_block_defines.svh =====
// Assertion macros used by the RTL of the YUV 4:2:0 to RGB555 converter.
`ifndef YUV420_TO_RGB555_BLOCK_DEFINES_SVH
`define YUV420_TO_RGB555_BLOCK_DEFINES_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define Y2R_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define Y2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds a fixed number of cycles later.
`define Y2R_ASSERT_LATER(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== hdl/y2r555_pkg.sv =====
`default_nettype none

package y2r555_pkg;

    // Command codes.
    localparam logic [2:0] CMD_FULL         = 3'd0;
    localparam logic [2:0] CMD_HALF         = 3'd1;
    localparam logic [2:0] CMD_TOP_LEFT     = 3'd2;
    localparam logic [2:0] CMD_TOP_RIGHT    = 3'd3;
    localparam logic [2:0] CMD_BOTTOM_LEFT  = 3'd4;
    localparam logic [2:0] CMD_BOTTOM_RIGHT = 3'd5;

    // Fixed-point constants of the BT.601 conversion.
    localparam int SCALE_MUL  = 76309;
    localparam int SCALE_HALF = 32768;
    localparam int ROUND_HALF = SCALE_MUL / 2;
    localparam int COEF_RV    = 104597;
    localparam int COEF_BU    = 132201;
    localparam int COEF_GU    = -25675;
    localparam int COEF_GV    = -53279;
    localparam int CHROMA_MID = 128;
    localparam int LUMA_FLOOR = 16;

    localparam logic [4:0]  CHAN_CAP   = 5'h1f;
    localparam logic [15:0] OPAQUE_PIX = 16'h8000;

    // A chroma offset stays within -222..220; a luma plus offset within -222..475.
    typedef logic signed [9:0]  offset_t;
    typedef logic signed [9:0]  sum_t;
    // The scaled sum reaches about 35 million in magnitude.
    typedef logic signed [27:0] prod_t;
    typedef offset_t offset_table_t [256];

    // Rounded chroma offset for every chroma code, half away from zero.
    function automatic offset_table_t build_offset_table(input int coef);
        offset_table_t tbl;
        int d;
        int q;
        for (int k = 0; k < 256; k++) begin
            d = coef * (k - CHROMA_MID);
            if (d > 0) begin
                q = (d + ROUND_HALF) / SCALE_MUL;
            end
            else begin
                q = -((-d + ROUND_HALF) / SCALE_MUL);
            end
            tbl[k] = offset_t'(q);
        end
        return tbl;
    endfunction

    localparam offset_table_t RV_TABLE = build_offset_table(COEF_RV);
    localparam offset_table_t BU_TABLE = build_offset_table(COEF_BU);
    localparam offset_table_t GU_TABLE = build_offset_table(COEF_GU);
    localparam offset_table_t GV_TABLE = build_offset_table(COEF_GV);

    // Clamp a scaled sum to 0..255, shift it down and cap it at five bits.
    function automatic logic [4:0] channel_value(input prod_t n, input logic [1:0] shift);
        logic [7:0] c8;
        logic [7:0] v;
        if (n[27]) begin
            c8 = 8'd0;
        end
        else if (|n[26:24]) begin
            c8 = 8'd255;
        end
        else begin
            c8 = n[23:16];
        end
        v = c8 >> shift;
        return (v > {3'd0, CHAN_CAP}) ? CHAN_CAP : v[4:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/yuv420_to_rgb555_block.sv =====
// Converts one 2x2 block of 4:2:0 luma with its shared Cb/Cr pair into four
// RGB555 pixels (red in bits 4..0, green 9..5, blue 14..10, bit 15 set).
// A new item may be started in every cycle; busy is always low. Each item's
// result appears on the pixel and write_mask ports with done high at the end of
// a four-stage pipeline: chroma offset lookup, luma plus offset, fixed-point
// scaling multiply, and clamp/pack.
// The receiver cannot stall, so results must be taken in the cycle they show.
// depth_shift (reset 3) is written through the APB port at addresses 0..3 and
// should only change while no item is in flight.
`default_nettype none

`include "yuv420_to_rgb555_block_defines.svh"

module yuv420_to_rgb555_block (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Item input.
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [7:0]  luma_top_left,
    input  wire logic [7:0]  luma_top_right,
    input  wire logic [7:0]  luma_bottom_left,
    input  wire logic [7:0]  luma_bottom_right,
    input  wire logic [7:0]  chroma_blue,
    input  wire logic [7:0]  chroma_red,
    // Result output.
    output logic             done,
    output logic [15:0]      pixel_top_left,
    output logic [15:0]      pixel_top_right,
    output logic [15:0]      pixel_bottom_left,
    output logic [15:0]      pixel_bottom_right,
    output logic [3:0]       write_mask,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LATENCY = 4;

    // Configuration register.
    logic [1:0] depth_shift_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {30'd0, depth_shift_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_shift_reg <= 2'd3;
        end
        else if (cfg_write)
        begin
            depth_shift_reg <= pwdata[1:0];
        end
    end

    assign busy = 1'b0;

    // Stage 1: chroma offset lookup, luma selection and write mask.
    logic                 s1_valid_reg;
    logic [7:0]           s1_luma_reg [4];
    y2r555_pkg::offset_t  s1_off_reg [3];
    logic [3:0]           s1_mask_reg;

    logic [7:0]           s1_luma_next [4];
    y2r555_pkg::offset_t  s1_off_next [3];
    logic [3:0]           s1_mask_next;

    always_comb
    begin
        s1_off_next[0] = y2r555_pkg::RV_TABLE[chroma_red];
        s1_off_next[1] = y2r555_pkg::GU_TABLE[chroma_blue]
                       + y2r555_pkg::GV_TABLE[chroma_red];
        s1_off_next[2] = y2r555_pkg::BU_TABLE[chroma_blue];

        s1_luma_next[0] = luma_top_left;
        s1_luma_next[1] = luma_top_right;
        s1_luma_next[2] = luma_bottom_left;
        s1_luma_next[3] = luma_bottom_right;
        if (command == y2r555_pkg::CMD_HALF)
        begin
            s1_luma_next[1] = luma_top_left;
            s1_luma_next[3] = luma_bottom_left;
        end

        unique case (command)
            y2r555_pkg::CMD_FULL:         s1_mask_next = 4'b1111;
            y2r555_pkg::CMD_HALF:         s1_mask_next = 4'b1111;
            y2r555_pkg::CMD_TOP_LEFT:     s1_mask_next = 4'b0001;
            y2r555_pkg::CMD_TOP_RIGHT:    s1_mask_next = 4'b0010;
            y2r555_pkg::CMD_BOTTOM_LEFT:  s1_mask_next = 4'b0100;
            y2r555_pkg::CMD_BOTTOM_RIGHT: s1_mask_next = 4'b1000;
            default:                      s1_mask_next = 4'b0000;
        endcase
    end

    // Stage 2: add each channel offset to each luma sample.
    logic              s2_valid_reg;
    y2r555_pkg::sum_t  s2_sum_reg [4][3];
    logic [3:0]        s2_mask_reg;
    y2r555_pkg::sum_t  s2_sum_next [4][3];

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s2_sum_next[p][c] = $signed({2'b00, s1_luma_reg[p]}) + s1_off_reg[c];
            end
        end
    end

    // Stage 3: fixed-point scaling, one multiplier per channel of each pixel.
    logic               s3_valid_reg;
    y2r555_pkg::prod_t  s3_prod_reg [4][3];
    logic [3:0]         s3_mask_reg;
    y2r555_pkg::prod_t  s3_prod_next [4][3];

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s3_prod_next[p][c] =
                    (y2r555_pkg::prod_t'(s2_sum_reg[p][c])
                     - y2r555_pkg::prod_t'(y2r555_pkg::LUMA_FLOOR))
                    * y2r555_pkg::prod_t'(y2r555_pkg::SCALE_MUL)
                    + y2r555_pkg::prod_t'(y2r555_pkg::SCALE_HALF);
            end
        end
    end

    // Stage 4: clamp, shift, cap, pack and blank the pixels that are not written.
    logic        done_reg;
    logic [15:0] pixel_reg [4];
    logic [3:0]  mask_reg;
    logic [15:0] pixel_next [4];

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            if (s3_mask_reg[p])
            begin
                pixel_next[p] = {1'b1,
                    y2r555_pkg::channel_value(s3_prod_reg[p][2], depth_shift_reg),
                    y2r555_pkg::channel_value(s3_prod_reg[p][1], depth_shift_reg),
                    y2r555_pkg::channel_value(s3_prod_reg[p][0], depth_shift_reg)};
            end
            else
            begin
                pixel_next[p] = y2r555_pkg::OPAQUE_PIX;
            end
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // Data registers of the pipeline.
    always_ff @(posedge clk)
    begin
        s1_luma_reg <= s1_luma_next;
        s1_off_reg  <= s1_off_next;
        s1_mask_reg <= s1_mask_next;
        s2_sum_reg  <= s2_sum_next;
        s2_mask_reg <= s1_mask_reg;
        s3_prod_reg <= s3_prod_next;
        s3_mask_reg <= s2_mask_reg;
    end

    // Result registers hold the last item until the next one arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= '{default: y2r555_pkg::OPAQUE_PIX};
            mask_reg  <= 4'd0;
        end
        else if (s3_valid_reg)
        begin
            pixel_reg <= pixel_next;
            mask_reg  <= s3_mask_reg;
        end
    end

    assign done               = done_reg;
    assign pixel_top_left     = pixel_reg[0];
    assign pixel_top_right    = pixel_reg[1];
    assign pixel_bottom_left  = pixel_reg[2];
    assign pixel_bottom_right = pixel_reg[3];
    assign write_mask         = mask_reg;

    // Checks on the pipeline.
    `Y2R_ASSERT_LATER(a_latency, clk, rst_n, start && !busy, LATENCY, done,
        "result missing after start")
    `Y2R_ASSERT_NOW(a_mask_shape, clk, rst_n, done,
        (write_mask == 4'b1111) || $onehot0(write_mask), "bad write mask")
    `Y2R_ASSERT_NOW(a_blank_unwritten, clk, rst_n, done,
        (write_mask[0] || (pixel_top_left == y2r555_pkg::OPAQUE_PIX))
        && (write_mask[1] || (pixel_top_right == y2r555_pkg::OPAQUE_PIX))
        && (write_mask[2] || (pixel_bottom_left == y2r555_pkg::OPAQUE_PIX))
        && (write_mask[3] || (pixel_bottom_right == y2r555_pkg::OPAQUE_PIX)),
        "unwritten pixel not blank")
    `Y2R_ASSERT_NEXT(a_hold_idle, clk, rst_n, !s3_valid_reg,
        $stable(pixel_top_left) && $stable(write_mask), "result changed without an item")

endmodule

`default_nettype wire
